// ===== rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// MD5 compression package
// Shared types, constant tables and helper functions for the MD5 block
// compression controller and datapath.
// ----------------------------------------------------------------------------
package md5_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned StepW  = 6;
	localparam int unsigned AddrW  = 4;

	typedef logic [WordW-1:0] word_t;
	typedef logic [StepW-1:0] step_t;
	typedef logic [AddrW-1:0] addr_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_ROUND,
		S_UPDATE,
		S_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        seed;      // reload the chaining value with the seed
		logic        wr_en;     // write an accepted word into the block buffer
		addr_t       wr_addr;
		logic        prep;      // load working words, prefetch step 0 operand
		logic        round_en;  // run one compression step
		step_t       step;
		logic        update;    // fold working words into the chaining value
		logic [1:0]  out_idx;
	} md5_cmd_t;

	localparam word_t SEED [0:3] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	localparam word_t SINE_K [0:63] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_AMT [0:15] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	// Message word index used by a given step.
	function automatic addr_t msg_index(input step_t k);
		addr_t j;
		addr_t r;
		j = k[3:0];
		case (k[5:4])
			2'd0:    r = j;
			2'd1:    r = addr_t'(j * 4'd5 + 4'd1);
			2'd2:    r = addr_t'(j * 4'd3 + 4'd5);
			2'd3:    r = addr_t'(j * 4'd7);
			default: r = j;
		endcase
		return r;
	endfunction

	function automatic word_t rotl(input word_t x, input logic [4:0] n);
		logic [2*WordW-1:0] t;
		t = {x, x} << n;
		return t[2*WordW-1:WordW];
	endfunction

endpackage

// ===== rtl/md5_ctrl.sv =====
// ----------------------------------------------------------------------------
// MD5 controller
// Sequences word intake, the 64 compression steps, the chaining update and
// the four-word digest output.
// ----------------------------------------------------------------------------
module md5_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             new_message,
	input  logic             final_block,
	output logic             busy,
	output logic             done,
	output logic [1:0]       word_index,
	output logic             last_word,
	output md5_pkg::md5_cmd_t cmd
);
	import md5_pkg::*;

	state_t     state_q, state_nx;
	addr_t      wcnt_q;
	step_t      step_q;
	logic [1:0] emit_q;
	logic       final_q;
	logic       accept;
	addr_t      addr;

	assign accept = start && (state_q == S_IDLE);
	// A new message restarts the block at word 0.
	assign addr   = new_message ? '0 : wcnt_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:   if (accept && addr == addr_t'(15)) state_nx = S_PREP;
			S_PREP:   state_nx = S_ROUND;
			S_ROUND:  if (step_q == step_t'(63)) state_nx = S_UPDATE;
			S_UPDATE: state_nx = final_q ? S_EMIT : S_IDLE;
			S_EMIT:   if (emit_q == 2'd3) state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.seed     = accept && new_message;
		cmd.wr_en    = accept;
		cmd.wr_addr  = addr;
		cmd.prep     = (state_q == S_PREP);
		cmd.round_en = (state_q == S_ROUND);
		cmd.step     = step_q;
		cmd.update   = (state_q == S_UPDATE);
		cmd.out_idx  = emit_q;
		busy         = (state_q != S_IDLE);
		done         = (state_q == S_EMIT);
		word_index   = emit_q;
		last_word    = (state_q == S_EMIT) && (emit_q == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wcnt_q  <= '0;
			step_q  <= '0;
			emit_q  <= '0;
			final_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				wcnt_q <= addr_t'(addr + 1'b1);
				if (addr == addr_t'(15)) final_q <= final_block;
			end
			if (state_q == S_ROUND) step_q <= step_t'(step_q + 1'b1);
			else step_q <= '0;
			if (state_q == S_EMIT) emit_q <= 2'(emit_q + 1'b1);
			else emit_q <= '0;
		end
	end

endmodule

// ===== rtl/md5_dp.sv =====
// ----------------------------------------------------------------------------
// MD5 datapath
// Block buffer, chaining value, working words and the one-step-per-cycle
// compression round logic.
// ----------------------------------------------------------------------------
module md5_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  md5_pkg::md5_cmd_t cmd,
	input  md5_pkg::word_t    msg_word,
	output md5_pkg::word_t    digest_word
);
	import md5_pkg::*;

	word_t buf_q [0:15];
	word_t cv_q  [0:3];
	word_t a_q, b_q, c_q, d_q;
	word_t kw_q;
	word_t fn;
	word_t sum;
	step_t nxt_step;
	step_t pre_step;
	word_t kw_nx;

	always_comb begin
		case (cmd.step[5:4])
			2'd0:    fn = (b_q & c_q) | (~b_q & d_q);
			2'd1:    fn = (d_q & b_q) | (~d_q & c_q);
			2'd2:    fn = b_q ^ c_q ^ d_q;
			2'd3:    fn = c_q ^ (b_q | ~d_q);
			default: fn = '0;
		endcase
		sum      = fn + a_q + kw_q;
		// The constant plus message word is fetched one step ahead.
		nxt_step = step_t'(cmd.step + 1'b1);
		pre_step = cmd.prep ? '0 : nxt_step;
		kw_nx    = SINE_K[pre_step] + buf_q[msg_index(pre_step)];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) buf_q[cmd.wr_addr] <= msg_word;
		if (cmd.prep || cmd.round_en) kw_q <= kw_nx;
		if (cmd.prep) begin
			a_q <= cv_q[0];
			b_q <= cv_q[1];
			c_q <= cv_q[2];
			d_q <= cv_q[3];
		end else if (cmd.round_en) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rotl(sum, ROT_AMT[{cmd.step[5:4], cmd.step[1:0]}]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) cv_q[i] <= SEED[i];
		end else if (cmd.seed) begin
			for (int i = 0; i < 4; i++) cv_q[i] <= SEED[i];
		end else if (cmd.update) begin
			cv_q[0] <= cv_q[0] + a_q;
			cv_q[1] <= cv_q[1] + b_q;
			cv_q[2] <= cv_q[2] + c_q;
			cv_q[3] <= cv_q[3] + d_q;
		end
	end

	assign digest_word = cv_q[cmd.out_idx];

endmodule

// ===== rtl/md5_block_compression.sv =====
// ----------------------------------------------------------------------------
// MD5 block compression
// Streams a padded message in 32-bit words and returns the four digest words.
// ----------------------------------------------------------------------------
// A word is taken whenever start is high and busy is low. After the sixteenth
// word of a block, busy stays high for a setup step, 64 compression steps
// through the single shared round unit (one step per cycle), and a chaining
// update. On the final block busy then stays high while done marks digest
// words A to D, one per cycle, with last_word on D. These words cannot be held
// off and must be taken as they appear.
module md5_block_compression (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  md5_pkg::word_t      msg_word,
	input  logic                new_message,
	input  logic                final_block,
	output logic                done,
	output md5_pkg::word_t      digest_word,
	output logic [1:0]          word_index,
	output logic                last_word
);
	import md5_pkg::*;

	md5_cmd_t cmd;

	md5_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.new_message (new_message),
		.final_block (final_block),
		.busy        (busy),
		.done        (done),
		.word_index  (word_index),
		.last_word   (last_word),
		.cmd         (cmd)
	);

	md5_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.msg_word    (msg_word),
		.digest_word (digest_word)
	);

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// MD5 block compression testbench
// Streams message words into the block in random bursts and runs an
// MD5 predictor on every accepted word. Each digest word that comes out is
// checked field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module tb;
	import md5_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_WORDS = 230;
	localparam int MIN_DIGEST_WORDS = 24;

	typedef struct {
		word_t w;
		logic  fresh;
		logic  fin;
		logic  pause;
	} msg_item_t;

	typedef struct {
		word_t      value;
		logic [1:0] pos;
		logic       is_last;
	} digest_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	word_t      msg_word = '0;
	logic       new_message = 1'b0;
	logic       final_block = 1'b0;
	logic       busy;
	logic       done;
	word_t      digest_word;
	logic [1:0] word_index;
	logic       last_word;

	msg_item_t pending[$];
	digest_t   digest_q[$];

	// Predictor state.
	word_t      chain_val [0:3];
	word_t      msg_block [0:15];
	logic [3:0] word_pos = '0;

	// Word position tracked while the stimulus is built, to count digests.
	int gen_pos = 0;
	int gen_digests = 0;

	logic word_taken = 1'b0;
	int   burst_left = 8;
	int   gap_left = 0;
	int   errors = 0;
	int   cycle_count = 0;

	md5_block_compression dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.msg_word    (msg_word),
		.new_message (new_message),
		.final_block (final_block),
		.done        (done),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic fold_block();
		word_t a, b, c, d, f, sum;
		int    g, r, sh;
		a = chain_val[0];
		b = chain_val[1];
		c = chain_val[2];
		d = chain_val[3];
		for (int k = 0; k < 64; k++) begin
			r = k / 16;
			case (r)
				0: begin
					f = (b & c) | (~b & d);
					g = k;
				end
				1: begin
					f = (d & b) | (~d & c);
					g = (5 * k + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * k + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * k) % 16;
				end
			endcase
			sum = f + a + SINE_K[k] + msg_block[g];
			sh = int'(ROT_AMT[r * 4 + k % 4]);
			a = d;
			d = c;
			c = b;
			b = b + ((sum << sh) | (sum >> (32 - sh)));
		end
		chain_val[0] = chain_val[0] + a;
		chain_val[1] = chain_val[1] + b;
		chain_val[2] = chain_val[2] + c;
		chain_val[3] = chain_val[3] + d;
	endtask

	task automatic absorb_word(input word_t w, input logic fresh, input logic fin);
		digest_t dw;
		if (fresh) begin
			for (int i = 0; i < 4; i++)
				chain_val[i] = SEED[i];
			word_pos = '0;
		end
		msg_block[word_pos] = w;
		if (word_pos != 4'd15) begin
			word_pos = word_pos + 4'd1;
		end else begin
			word_pos = '0;
			fold_block();
			// The final flag only counts on the word that closes a block.
			if (fin) begin
				for (int i = 0; i < 4; i++) begin
					dw.value = chain_val[i];
					dw.pos = 2'(i);
					dw.is_last = (i == 3);
					digest_q.push_back(dw);
				end
			end
		end
	endtask

	task automatic push_word(input word_t w, input logic fresh, input logic fin);
		msg_item_t it;
		it.w = w;
		it.fresh = fresh;
		it.fin = fin;
		it.pause = 1'b0;
		pending.push_back(it);
		if (fresh)
			gen_pos = 0;
		if (gen_pos == 15) begin
			if (fin)
				gen_digests += 4;
			gen_pos = 0;
		end else begin
			gen_pos++;
		end
	endtask

	task automatic push_pause();
		msg_item_t it;
		it.w = '0;
		it.fresh = 1'b0;
		it.fin = 1'b0;
		it.pause = 1'b1;
		pending.push_back(it);
	endtask

	function automatic word_t pick_word();
		case ($urandom_range(0, 15))
			0:       return 32'h00000000;
			1:       return 32'hffffffff;
			2:       return 32'h80000000;
			3:       return 32'h00000001;
			default: return $urandom();
		endcase
	endfunction

	// Driver: a word stays on the inputs until it has been taken.
	always @(negedge clk) begin : drive
		msg_item_t nxt;
		if (arst_n && (!start || word_taken)) begin
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending.size() == 0) begin
				start <= 1'b0;
			end else if (pending[0].pause) begin
				start <= 1'b0;
				if (digest_q.size() == 0)
					nxt = pending.pop_front();
			end else begin
				nxt = pending.pop_front();
				start <= 1'b1;
				msg_word <= nxt.w;
				new_message <= nxt.fresh;
				final_block <= nxt.fin;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					if ($urandom_range(0, 3) == 0)
						gap_left <= 0;
					else if ($urandom_range(0, 9) == 0)
						gap_left <= $urandom_range(20, 90);
					else
						gap_left <= $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Monitor: checks digest words and feeds accepted words to the predictor.
	always @(posedge clk) begin : watch
		digest_t exp_d;
		if (arst_n && done !== 1'b0) begin
			if (digest_q.size() == 0) begin
				$display("%0t: unexpected digest word %h index %0d last %b",
					$time, digest_word, word_index, last_word);
				errors++;
			end else begin
				exp_d = digest_q.pop_front();
				if (digest_word !== exp_d.value) begin
					$display("%0t: digest_word expected %h actual %h",
						$time, exp_d.value, digest_word);
					errors++;
				end
				if (word_index !== exp_d.pos) begin
					$display("%0t: word_index expected %0d actual %0d",
						$time, exp_d.pos, word_index);
					errors++;
				end
				if (last_word !== exp_d.is_last) begin
					$display("%0t: last_word expected %b actual %b",
						$time, exp_d.is_last, last_word);
					errors++;
				end
			end
		end
		if (start && busy === 1'b0) begin
			word_taken <= 1'b1;
			absorb_word(msg_word, new_message, final_block);
		end else begin
			word_taken <= 1'b0;
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		int    rand_items;
		int    kind;
		int    nblk;
		int    n;
		int    msg_n;
		logic  fresh;
		word_t extremes [0:7];

		for (int i = 0; i < 4; i++)
			chain_val[i] = SEED[i];
		for (int i = 0; i < 16; i++)
			msg_block[i] = '0;

		// A message cut off mid-block, with final flags on words that do
		// not close a block; the next new message must drop it.
		push_word(32'h00000000, 1'b1, 1'b1);
		push_word(32'hffffffff, 1'b0, 1'b0);
		push_word(32'h12345678, 1'b0, 1'b1);
		push_word(32'h00000001, 1'b0, 1'b0);
		push_word(32'h80000000, 1'b0, 1'b1);

		// One full final block with extreme words.
		extremes = '{32'hffffffff, 32'h00000000, 32'h80000000, 32'h00000001,
			32'haaaaaaaa, 32'h55555555, 32'h7fffffff, 32'hfffffffe};
		for (int i = 0; i < 16; i++)
			push_word((i < 8) ? extremes[i] : $urandom(), i == 0,
				(i == 15) || (i % 3 == 1));
		push_pause();

		rand_items = 0;
		msg_n = 0;
		while (rand_items < RANDOM_WORDS || gen_digests < MIN_DIGEST_WORDS) begin
			kind = $urandom_range(0, 19);
			if (kind < 15) begin
				// Well-formed message; the second one continues the chaining
				// value without a new-message flag.
				nblk = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
				fresh = (msg_n == 1) ? 1'b0 : ($urandom_range(0, 7) != 0);
				for (int b = 0; b < nblk; b++)
					for (int i = 0; i < 16; i++)
						push_word(pick_word(), fresh && b == 0 && i == 0,
							(b == nblk - 1) ? (i == 15 || $urandom_range(0, 1) == 1)
								: (i != 15 && $urandom_range(0, 3) == 0));
				rand_items += 16 * nblk;
				msg_n++;
			end else if (kind < 18) begin
				// Broken message that stops part way through a block.
				n = $urandom_range(1, 15);
				for (int i = 0; i < n; i++)
					push_word(pick_word(), i == 0 && $urandom_range(0, 1) == 1,
						1'($urandom_range(0, 1)));
				rand_items += n;
			end else if (kind == 18) begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					push_word($urandom(), $urandom_range(0, 3) == 0,
						1'($urandom_range(0, 1)));
				rand_items += n;
			end else begin
				push_pause();
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || start)
			@(posedge clk);
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/md5_pkg.sv
rtl/md5_ctrl.sv
rtl/md5_dp.sv
rtl/md5_block_compression.sv
tb/tb.sv
